@@ hdl/cld_pkg.sv @@
package cld_pkg;

   localparam int MSG_BITS    = 4;
   localparam int PARITY_BITS = 4;
   localparam int CODE_BITS   = MSG_BITS + PARITY_BITS;
   localparam int NUM_SYN     = 1 << PARITY_BITS;
   localparam int H_BITS      = 16;
   localparam int WT_W        = $clog2(CODE_BITS + 1);
   localparam int FILL_W      = PARITY_BITS + 1;

   typedef logic [CODE_BITS-1:0]   word_type;
   typedef logic [PARITY_BITS-1:0] syn_type;
   typedef logic [WT_W-1:0]        weight_type;
   typedef logic [FILL_W-1:0]      fill_type;
   typedef logic [H_BITS-1:0]      hmat_type;

   typedef enum logic [1:0] {
      FUNC_ENCODE = 2'd0,
      FUNC_DECODE = 2'd1,
      FUNC_BUILD  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_BUILD
   } state_type;

   typedef struct packed {
      logic clear;
      logic wr_en;
   } store_ctl_type;

endpackage

@@ hdl/coset_leader_syndrome_decoder_top.sv @@
// Coset-leader syndrome decoder for a systematic (8,4) binary code.
// Command channel: a beat is taken on a clock edge with start high and busy
// low; req_func selects encode (0), decode (1) or leader-table build (2).
// Result channel: rsp_valid is high for exactly one cycle per command with
// the result fields alongside; the receiver cannot stall it, so it must
// take every result in that cycle.
// Encode and the unused code answer in the cycle after the command,
// with busy staying low, so they can run back to back. Decode answers
// after a registered syndrome and table read, then a registered
// correction; busy is high in between, so a new command waits for the result.
// Build walks candidate words one per cycle through the shared syndrome and
// weight unit, all 256 words in one pass per weight from 0 up, descending
// value within a pass, and stops as soon as all 16 syndromes hold a leader;
// words up to weight 1 cover at most 9 and the parity-only words cover all
// by weight 4, so the build answers in the pass of weight 2, 3 or 4, with
// busy high throughout.
// csr_data writes the 16-bit parity matrix; csr_ready is always high.
// Reset clears the matrix, the table-built flag and every leader valid
// bit; a decode before a build returns status 1.
module coset_leader_syndrome_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_word,
   output logic        rsp_valid,
   output logic [7:0]  rsp_result_word,
   output logic [3:0]  rsp_syndrome,
   output logic [7:0]  rsp_error_pattern,
   output logic        rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   cld_pkg::state_type      state_ff, state_in;
   cld_pkg::hmat_type       hmat_ff;
   logic                    built_ff, built_in;
   cld_pkg::word_type       cand_ff, cand_in;
   cld_pkg::weight_type     wt_ff, wt_in;
   cld_pkg::fill_type       filled_ff, filled_in;
   cld_pkg::word_type       word_ff, word_in;
   cld_pkg::syn_type        syn_ff, syn_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              result_ff, result_in;
   logic [3:0]              rsp_syn_ff, rsp_syn_in;
   logic [7:0]              err_ff, err_in;
   logic                    status_ff, status_in;

   logic                    accept;
   cld_pkg::func_type       func;
   cld_pkg::word_type       in_word;
   cld_pkg::word_type       unit_word;
   cld_pkg::syn_type        unit_syn;
   cld_pkg::weight_type     unit_wt;
   cld_pkg::store_ctl_type  store_ctl;
   logic                    look_valid;
   cld_pkg::word_type       rd_data;
   logic                    rd_valid;
   logic                    hit;
   logic                    build_done;
   cld_pkg::word_type       fixed;

   assign busy      = (state_ff != cld_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign func      = cld_pkg::func_type'(req_func);
   assign in_word   = req_data_word[cld_pkg::CODE_BITS-1:0];

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_word   = result_ff;
   assign rsp_syndrome      = rsp_syn_ff;
   assign rsp_error_pattern = err_ff;
   assign rsp_status        = status_ff;

   // one unit serves encode parity, decode syndrome and the build walk
   always_comb begin
      if (state_ff == cld_pkg::ST_BUILD) begin
         unit_word = cand_ff;
      end else if (func == cld_pkg::FUNC_ENCODE) begin
         unit_word = {in_word[cld_pkg::CODE_BITS-1:cld_pkg::PARITY_BITS],
                      cld_pkg::syn_type'(0)};
      end else begin
         unit_word = in_word;
      end
   end

   cld_syndrome_unit u_syn (
      .word     (unit_word),
      .hmat     (hmat_ff),
      .syndrome (unit_syn),
      .weight   (unit_wt)
   );

   cld_leader_store u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (store_ctl),
      .addr       (unit_syn),
      .wr_data    (cand_ff),
      .look_valid (look_valid),
      .rd_data    (rd_data),
      .rd_valid   (rd_valid)
   );

   assign hit = (state_ff == cld_pkg::ST_BUILD) && (unit_wt == wt_ff) && !look_valid;

   always_comb begin
      filled_in = filled_ff + cld_pkg::fill_type'(hit);
      build_done = (filled_in == cld_pkg::fill_type'(cld_pkg::NUM_SYN)) ||
                   ((cand_ff == '0) &&
                    (wt_ff == cld_pkg::weight_type'(cld_pkg::CODE_BITS)));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cld_pkg::ST_IDLE: begin
            if (accept && func == cld_pkg::FUNC_DECODE) begin
               state_in = cld_pkg::ST_DECODE;
            end else if (accept && func == cld_pkg::FUNC_BUILD) begin
               state_in = cld_pkg::ST_BUILD;
            end
         end
         cld_pkg::ST_DECODE: begin
            state_in = cld_pkg::ST_IDLE;
         end
         cld_pkg::ST_BUILD: begin
            if (build_done) begin
               state_in = cld_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cld_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      built_in     = built_ff;
      cand_in      = cand_ff;
      wt_in        = wt_ff;
      word_in      = word_ff;
      syn_in       = syn_ff;
      store_ctl    = '0;
      rsp_valid_in = 1'b0;
      result_in    = '0;
      rsp_syn_in   = '0;
      err_in       = '0;
      status_in    = 1'b0;
      fixed        = word_ff ^ rd_data;
      unique case (state_ff)
         cld_pkg::ST_IDLE: begin
            if (accept) begin
               word_in = in_word;
               syn_in  = unit_syn;
               unique case (func)
                  cld_pkg::FUNC_ENCODE: begin
                     rsp_valid_in = 1'b1;
                     result_in = 8'({in_word[cld_pkg::CODE_BITS-1:cld_pkg::PARITY_BITS],
                                     unit_syn});
                  end
                  cld_pkg::FUNC_DECODE: begin
                  end
                  cld_pkg::FUNC_BUILD: begin
                     store_ctl.clear = 1'b1;
                     cand_in = '1;
                     wt_in   = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         cld_pkg::ST_DECODE: begin
            rsp_valid_in = 1'b1;
            if (!built_ff || !rd_valid) begin
               status_in = 1'b1;
            end else begin
               result_in  = 8'(fixed[cld_pkg::CODE_BITS-1:cld_pkg::PARITY_BITS]);
               rsp_syn_in = 4'(syn_ff);
               err_in     = 8'(rd_data);
            end
         end
         cld_pkg::ST_BUILD: begin
            store_ctl.wr_en = hit;
            if (build_done) begin
               rsp_valid_in = 1'b1;
               built_in     = 1'b1;
            end else if (cand_ff == '0) begin
               cand_in = '1;
               wt_in   = wt_ff + cld_pkg::weight_type'(1);
            end else begin
               cand_in = cand_ff - cld_pkg::word_type'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cld_pkg::ST_IDLE;
         built_ff     <= 1'b0;
         hmat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            hmat_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && func == cld_pkg::FUNC_BUILD)) begin
         filled_ff <= '0;
      end else if (state_ff == cld_pkg::ST_BUILD) begin
         filled_ff <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff    <= cand_in;
      wt_ff      <= wt_in;
      word_ff    <= word_in;
      syn_ff     <= syn_in;
      result_ff  <= result_in;
      rsp_syn_ff <= rsp_syn_in;
      err_ff     <= err_in;
      status_ff  <= status_in;
   end

`ifndef SYNTHESIS
   a_fast_answer: assert property (@(posedge clock) disable iff (reset)
      (accept && func != cld_pkg::FUNC_DECODE && func != cld_pkg::FUNC_BUILD)
      |=> (rsp_valid && !busy))
      else $error("encode beat did not answer in one cycle");

   a_decode_answer: assert property (@(posedge clock) disable iff (reset)
      (accept && func == cld_pkg::FUNC_DECODE) |=> ##1 (rsp_valid && !busy))
      else $error("decode beat did not answer in two cycles");

   a_status_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |->
      (rsp_result_word == '0 && rsp_syndrome == '0 && rsp_error_pattern == '0))
      else $error("failed decode carries nonzero fields");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cld_pkg::ST_BUILD) |->
      (filled_ff < cld_pkg::fill_type'(cld_pkg::NUM_SYN)))
      else $error("build walk continued past a full table");

   a_build_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && func == cld_pkg::FUNC_BUILD) |=> (busy && !rsp_valid))
      else $error("build did not hold busy");
`endif

endmodule

@@ hdl/cld_syndrome_unit.sv @@
module cld_syndrome_unit (
   input  cld_pkg::word_type   word,
   input  cld_pkg::hmat_type   hmat,
   output cld_pkg::syn_type    syndrome,
   output cld_pkg::weight_type weight
);

   always_comb begin
      int idx;
      logic acc;
      for (int j = 0; j < cld_pkg::PARITY_BITS; j++) begin
         acc = word[cld_pkg::PARITY_BITS-1-j];
         for (int i = 0; i < cld_pkg::MSG_BITS; i++) begin
            idx = i * cld_pkg::PARITY_BITS + j;
            // h bits beyond the register read as zero
            if (idx < cld_pkg::H_BITS) begin
               acc = acc ^ (word[cld_pkg::CODE_BITS-1-i] & hmat[idx]);
            end
         end
         syndrome[cld_pkg::PARITY_BITS-1-j] = acc;
      end
   end

   always_comb begin
      weight = '0;
      for (int b = 0; b < cld_pkg::CODE_BITS; b++) begin
         weight = weight + cld_pkg::weight_type'(word[b]);
      end
   end

endmodule

@@ hdl/cld_leader_store.sv @@
module cld_leader_store (
   input  logic                    clock,
   input  logic                    reset,
   input  cld_pkg::store_ctl_type  ctl,
   input  cld_pkg::syn_type        addr,
   input  cld_pkg::word_type       wr_data,
   output logic                    look_valid,
   output cld_pkg::word_type       rd_data,
   output logic                    rd_valid
);

   cld_pkg::word_type               mem [cld_pkg::NUM_SYN];
   logic [cld_pkg::NUM_SYN-1:0]     valid_ff;
   cld_pkg::word_type               rd_data_ff;
   logic                            rd_valid_ff;

   assign look_valid = valid_ff[addr];
   assign rd_data    = rd_data_ff;
   assign rd_valid   = rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[addr];
      end
   end

endmodule
